// ===== design/sensor_reading_compensation_top_assert.svh =====
// Assertion macros for the sensor reading compensation block
`ifndef SENSOR_READING_COMPENSATION_TOP_ASSERT_SVH
`define SENSOR_READING_COMPENSATION_TOP_ASSERT_SVH

// same-cycle implication
`define SRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sensor compensation check failed");

// next-cycle implication
`define SRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sensor compensation check failed");

`endif

// ===== design/src_pkg.sv =====
// Shared types and constants for the sensor reading compensation block
`timescale 1ns / 1ps
package src_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;
  localparam int DivW = 32;

  localparam logic [CfgIdxW-1:0] REG_TEMP_COEFS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_LOW = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_HUM = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUM_COEFS = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TEMP_OFFSET = 3'd5;

  localparam logic signed [31:0] HUM_MAX = 32'sd419430400;

  // results that ride alongside the pressure divide
  typedef struct packed {
    logic signed [31:0] tc;
    logic [16:0]        hq;
    logic               dbl;
    logic               zero;
  } div_side_t;

endpackage

// ===== design/src_if.sv =====
// Reading and result channel interfaces
`timescale 1ns / 1ps
interface src_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] adc_pressure;
  logic [19:0] adc_temperature;
  logic [15:0] adc_humidity;
  modport source (output valid, adc_pressure, adc_temperature, adc_humidity, input ready);
  modport sink (input valid, adc_pressure, adc_temperature, adc_humidity, output ready);
endinterface

interface src_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic [31:0]        pressure_pa;
  logic [16:0]        humidity_q10;
  modport source (output valid, temperature_centi, pressure_pa, humidity_q10, input ready);
  modport sink (input valid, temperature_centi, pressure_pa, humidity_q10, output ready);
endinterface

// ===== design/sensor_reading_compensation_top.sv =====
// Path: an accepted reading passes the front stages, the pressure divider and the post stages to the result word.
// Throughput: one reading per cycle unless the pipe holds; the 32-stage pressure divider sets the depth.
// The whole pipe advances together; it holds while a result word waits unread.
// Reset: synchronous, clears all valid bits and every calibration register to 0.
`timescale 1ns / 1ps
`include "sensor_reading_compensation_top_assert.svh"
module sensor_reading_compensation_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [src_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [src_pkg::CfgDataW-1:0]  cfg_data,
  src_in_if.sink                        req,
  src_out_if.source                     rsp
);
  import src_pkg::*;

  // calibration registers
  logic [47:0] temp_coefs;
  logic [63:0] press_low;
  logic [63:0] press_high;
  logic [47:0] press_hum;
  logic [31:0] hum_coefs;
  logic signed [15:0] temp_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coefs <= '0;
      press_low <= '0;
      press_high <= '0;
      press_hum <= '0;
      hum_coefs <= '0;
      temp_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TEMP_COEFS:  temp_coefs <= cfg_data[47:0];
        REG_PRESS_LOW:   press_low <= cfg_data;
        REG_PRESS_HIGH:  press_high <= cfg_data;
        REG_PRESS_HUM:   press_hum <= cfg_data[47:0];
        REG_HUM_COEFS:   hum_coefs <= cfg_data[31:0];
        REG_TEMP_OFFSET: temp_offset <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  logic [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0] h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0] h6;

  assign t1 = temp_coefs[15:0];
  assign t2 = $signed(temp_coefs[31:16]);
  assign t3 = $signed(temp_coefs[47:32]);
  assign p1 = press_low[15:0];
  assign p2 = $signed(press_low[31:16]);
  assign p3 = $signed(press_low[47:32]);
  assign p4 = $signed(press_low[63:48]);
  assign p5 = $signed(press_high[15:0]);
  assign p6 = $signed(press_high[31:16]);
  assign p7 = $signed(press_high[47:32]);
  assign p8 = $signed(press_high[63:48]);
  assign p9 = $signed(press_hum[15:0]);
  assign h1 = press_hum[23:16];
  assign h2 = $signed(press_hum[39:24]);
  assign h3 = press_hum[47:40];
  assign h4 = $signed(hum_coefs[11:0]);
  assign h5 = $signed(hum_coefs[23:12]);
  assign h6 = $signed(hum_coefs[31:24]);

  // pipeline control
  logic [11:0] vld;
  logic [2:0]  pv;
  logic        adv;
  logic        dv;

  assign adv = !pv[2] || rsp.ready;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      pv <= '0;
    end else if (adv) begin
      vld <= {vld[10:0], req.valid};
      pv <= {pv[1:0], dv};
    end
  end

  // stage 1: temperature differences and products
  logic signed [18:0] d1;
  logic signed [17:0] d2;
  logic signed [34:0] s1_m1;
  logic signed [35:0] s1_sq;
  logic [19:0] s1_adcp;
  logic [15:0] s1_adch;

  assign d1 = $signed({2'b0, req.adc_temperature[19:3]}) - $signed({2'b0, t1, 1'b0});
  assign d2 = $signed({2'b0, req.adc_temperature[19:4]}) - $signed({2'b0, t1});

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_m1 <= 35'(d1) * 35'(t2);
      s1_sq <= 36'(d2) * 36'(d2);
      s1_adcp <= req.adc_pressure;
      s1_adch <= req.adc_humidity;
    end
  end

  // stage 2
  logic signed [23:0] s2_e1;
  logic signed [37:0] s2_m2;
  logic [19:0] s2_adcp;
  logic [15:0] s2_adch;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_e1 <= 24'(s1_m1 >>> 11);
      s2_m2 <= 38'($signed({1'b0, s1_sq[32:12]})) * 38'(t3);
      s2_adcp <= s1_adcp;
      s2_adch <= s1_adch;
    end
  end

  // stage 3: fine temperature
  logic signed [31:0] s3_tf;
  logic [19:0] s3_adcp;
  logic [15:0] s3_adch;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tf <= 32'(25'(s2_e1) + 25'(s2_m2 >>> 14));
      s3_adcp <= s2_adcp;
      s3_adch <= s2_adch;
    end
  end

  // stage 4: temperature result, pressure and humidity bases
  logic signed [34:0] tcw, tcs;
  logic signed [31:0] s4_tc, s4_v1, s4_h;
  logic [19:0] s4_adcp;
  logic [15:0] s4_adch;

  always_comb begin
    tcw = 35'(s3_tf) * 35'sd5 + 35'sd128;
    // magnitude stays below 2^27, so taking the low 32 bits loses nothing
    tcs = (tcw >>> 8) + 35'(temp_offset);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_tc <= tcs[31:0];
      s4_v1 <= (s3_tf >>> 1) - 32'sd64000;
      s4_h <= s3_tf - 32'sd76800;
      s4_adcp <= s3_adcp;
      s4_adch <= s3_adch;
    end
  end

  // stage 5: first products
  logic signed [31:0] q4;
  logic signed [31:0] s5_tc, s5_qq, s5_v1p5, s5_pbm, s5_hh5, s5_hh6, s5_hh3;
  logic [19:0] s5_adcp;
  logic [15:0] s5_adch;

  assign q4 = s4_v1 >>> 2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_tc <= s4_tc;
      s5_qq <= q4 * q4;
      s5_v1p5 <= s4_v1 * 32'(p5);
      s5_pbm <= 32'(p2) * s4_v1;
      s5_hh5 <= s4_h * 32'(h5);
      s5_hh6 <= s4_h * 32'(h6);
      s5_hh3 <= s4_h * $signed({24'b0, h3});
      s5_adcp <= s4_adcp;
      s5_adch <= s4_adch;
    end
  end

  // stage 6
  logic signed [31:0] xs;
  logic signed [31:0] s6_tc, s6_v2m, s6_pam, s6_y2, s6_y1, s6_x1, s6_v1p5, s6_pbm;
  logic [19:0] s6_adcp;

  assign xs = $signed({2'b0, s5_adch, 14'b0}) - (32'(h4) <<< 20) - s5_hh5 + 32'sd16384;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_tc <= s5_tc;
      s6_v2m <= (s5_qq >>> 11) * 32'(p6);
      s6_pam <= 32'(p3) * (s5_qq >>> 13);
      s6_y2 <= (s5_hh3 >>> 11) + 32'sd32768;
      s6_y1 <= s5_hh6 >>> 10;
      s6_x1 <= xs >>> 15;
      s6_v1p5 <= s5_v1p5;
      s6_pbm <= s5_pbm;
      s6_adcp <= s5_adcp;
    end
  end

  // stage 7
  logic signed [31:0] v2b, v1b;
  logic signed [31:0] s7_tc, s7_v2c, s7_w, s7_ym, s7_x1;
  logic [19:0] s7_adcp;

  always_comb begin
    v2b = s6_v2m + (s6_v1p5 <<< 1);
    v1b = ((s6_pam >>> 3) + (s6_pbm >>> 1)) >>> 18;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_tc <= s6_tc;
      s7_v2c <= (v2b >>> 2) + (32'(p4) <<< 16);
      s7_w <= 32'sd32768 + v1b;
      s7_ym <= s6_y1 * s6_y2;
      s7_x1 <= s6_x1;
      s7_adcp <= s6_adcp;
    end
  end

  // stage 8: divisor
  logic signed [31:0] v1c, yb;
  logic signed [31:0] s8_tc, s8_v2s, s8_yh, s8_x1;
  logic [31:0] s8_den;
  logic [19:0] s8_adcp;

  always_comb begin
    v1c = (s7_w * $signed({16'b0, p1})) >>> 15;
    yb = (s7_ym >>> 10) + 32'sd2097152;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_tc <= s7_tc;
      s8_den <= $unsigned(v1c);
      s8_v2s <= s7_v2c >>> 12;
      s8_yh <= yb * 32'(h2) + 32'sd8192;
      s8_x1 <= s7_x1;
      s8_adcp <= s7_adcp;
    end
  end

  // stage 9: scaled numerator
  logic [31:0] p0;
  logic signed [31:0] s9_tc, s9_h2;
  logic [31:0] s9_pm, s9_den;

  assign p0 = 32'd1048576 - {12'b0, s8_adcp} - $unsigned(s8_v2s);

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_tc <= s8_tc;
      s9_pm <= p0 * 32'd3125;
      s9_den <= s8_den;
      s9_h2 <= s8_x1 * (s8_yh >>> 14);
    end
  end

  // stage 10: choose double-then-divide or divide-then-double
  logic signed [31:0] r9;
  logic signed [31:0] s10_tc, s10_h2, s10_rr;
  logic [31:0] s10_num, s10_den;
  logic s10_dbl;

  assign r9 = s9_h2 >>> 15;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_tc <= s9_tc;
      s10_dbl <= s9_pm[31];
      s10_num <= s9_pm[31] ? s9_pm : {s9_pm[30:0], 1'b0};
      s10_den <= s9_den;
      s10_h2 <= s9_h2;
      s10_rr <= r9 * r9;
    end
  end

  // stage 11
  logic signed [31:0] s11_tc, s11_h2, s11_zm;
  logic [31:0] s11_num, s11_den;
  logic s11_dbl;

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_tc <= s10_tc;
      s11_dbl <= s10_dbl;
      s11_num <= s10_num;
      s11_den <= s10_den;
      s11_h2 <= s10_h2;
      s11_zm <= (s10_rr >>> 7) * $signed({24'b0, h1});
    end
  end

  // stage 12: humidity clamp and scale
  logic signed [31:0] h3v, hc;
  div_side_t s12_side;
  logic [31:0] s12_num, s12_den;

  always_comb begin
    h3v = s11_h2 - (s11_zm >>> 4);
    if (h3v < 0) begin
      hc = '0;
    end else if (h3v > HUM_MAX) begin
      hc = HUM_MAX;
    end else begin
      hc = h3v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_side.tc <= s11_tc;
      s12_side.hq <= hc[28:12];
      s12_side.dbl <= s11_dbl;
      s12_side.zero <= (s11_den == '0);
      s12_num <= s11_num;
      s12_den <= s11_den;
    end
  end

  // pressure divide
  logic [31:0] dq;
  div_side_t dside;

  src_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (vld[11]),
    .num      (s12_num),
    .den      (s12_den),
    .side     (s12_side),
    .out_vld  (dv),
    .quo      (dq),
    .side_out (dside)
  );

  // post 1: quotient, correction products
  logic [31:0] pq, uq;
  logic [31:0] t1_p, t1_uu;
  logic signed [31:0] t1_c2m;
  div_side_t t1_side;

  always_comb begin
    pq = dside.dbl ? {dq[30:0], 1'b0} : dq;
    uq = pq >> 3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_p <= pq;
      t1_uu <= uq * uq;
      t1_c2m <= $signed({2'b0, pq[31:2]}) * 32'(p8);
      t1_side <= dside;
    end
  end

  // post 2
  logic [31:0] t2_p;
  logic signed [31:0] t2_c2m, t2_c1m;
  div_side_t t2_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_p <= t1_p;
      t2_c2m <= t1_c2m;
      t2_c1m <= 32'(p9) * $signed({13'b0, t1_uu[31:13]});
      t2_side <= t1_side;
    end
  end

  // post 3: final correction, output word
  logic signed [31:0] sc;
  logic [31:0] o_p;
  logic signed [31:0] o_tc;
  logic [16:0] o_hq;

  assign sc = ((t2_c1m >>> 12) + (t2_c2m >>> 13) + 32'(p7)) >>> 4;

  always_ff @(posedge clk) begin
    if (adv) begin
      o_p <= t2_side.zero ? 32'd0 : t2_p + $unsigned(sc);
      o_tc <= t2_side.tc;
      o_hq <= t2_side.hq;
    end
  end

  assign rsp.valid = pv[2];
  assign rsp.temperature_centi = o_tc;
  assign rsp.pressure_pa = o_p;
  assign rsp.humidity_q10 = o_hq;

  `SRC_ASSERT_NOW(a_hum_range, rsp.valid, rsp.humidity_q10 <= 17'd102400)
  `SRC_ASSERT_NEXT(a_enter, req.valid && req.ready, vld[0])
  `SRC_ASSERT_NEXT(a_hold_front, !adv, $stable(vld))
  `SRC_ASSERT_NEXT(a_hold_back, !adv, $stable(pv))

endmodule

// ===== design/src_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage
`timescale 1ns / 1ps
module src_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [31:0]       num,
  input  logic [31:0]       den,
  input  src_pkg::div_side_t side,
  output logic              out_vld,
  output logic [31:0]       quo,
  output src_pkg::div_side_t side_out
);
  import src_pkg::*;

  logic [DivW-1:0]   vld;
  logic [31:0]       rem   [DivW];
  logic [31:0]       nq    [DivW];
  logic [31:0]       dn    [DivW];
  div_side_t         sd    [DivW];
  logic [31:0]       rem_next [DivW];
  logic [31:0]       nq_next  [DivW];

  always_comb begin
    logic [31:0] r_src;
    logic [31:0] n_src;
    logic [31:0] d_src;
    logic [32:0] trial;
    logic        geq;
    for (int i = 0; i < DivW; i++) begin
      r_src = (i == 0) ? 32'd0 : rem[(i == 0) ? 0 : i-1];
      n_src = (i == 0) ? num : nq[(i == 0) ? 0 : i-1];
      d_src = (i == 0) ? den : dn[(i == 0) ? 0 : i-1];
      trial = {r_src, n_src[31]};
      geq = trial >= {1'b0, d_src};
      rem_next[i] = geq ? 32'(trial - {1'b0, d_src}) : trial[31:0];
      nq_next[i] = {n_src[30:0], geq};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DivW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DivW; i++) begin
        rem[i] <= rem_next[i];
        nq[i] <= nq_next[i];
        dn[i] <= (i == 0) ? den : dn[(i == 0) ? 0 : i-1];
        sd[i] <= (i == 0) ? side : sd[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign out_vld = vld[DivW-1];
  assign quo = nq[DivW-1];
  assign side_out = sd[DivW-1];

endmodule

// ===== bench/tb_sensor_reading_compensation_top.sv =====
// Self-checking bench for the sensor reading compensation top: random words, random stalls.
`timescale 1ns / 1ps
module tb_sensor_reading_compensation_top;
  import src_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;
  localparam int DrainCycles = 80;
  localparam int CycleLimit = 600000;

  typedef struct {
    int          temp_centi;
    int unsigned press_pa;
    logic [16:0] hum_q10;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  src_in_if in_ch ();
  src_out_if out_ch ();

  sensor_reading_compensation_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .req(in_ch), .rsp(out_ch)
  );

  // shadow calibration registers
  logic [47:0] cal_temp;
  logic [63:0] cal_press_lo;
  logic [63:0] cal_press_hi;
  logic [47:0] cal_press_hum;
  logic [31:0] cal_hum;
  logic signed [15:0] cal_offset;

  reading_t predicted_readings[$];
  bit idle_on = 1'b1;
  int mismatches = 0;
  longint cycle_count = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.adc_pressure = '0;
    in_ch.adc_temperature = '0;
    in_ch.adc_humidity = '0;
    out_ch.ready = 1'b0;
  end

  function automatic reading_t compensate(input logic [19:0] ap, input logic [19:0] at,
                                          input logic [15:0] ah);
    reading_t res;
    longint t1, t2, t3, d1, d2, e1, e2, tcl;
    int p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
    int t_fine, v1, v2, q, qq, pa, pb, sq, c1, c2, s;
    int h, x1, y1, y2, y, r, z;
    int unsigned p, dv, u;
    t1 = longint'(cal_temp[15:0]);
    t2 = longint'($signed(cal_temp[31:16]));
    t3 = longint'($signed(cal_temp[47:32]));
    p1 = int'(cal_press_lo[15:0]);
    p2 = int'($signed(cal_press_lo[31:16]));
    p3 = int'($signed(cal_press_lo[47:32]));
    p4 = int'($signed(cal_press_lo[63:48]));
    p5 = int'($signed(cal_press_hi[15:0]));
    p6 = int'($signed(cal_press_hi[31:16]));
    p7 = int'($signed(cal_press_hi[47:32]));
    p8 = int'($signed(cal_press_hi[63:48]));
    p9 = int'($signed(cal_press_hum[15:0]));
    h1 = int'(cal_press_hum[23:16]);
    h2 = int'($signed(cal_press_hum[39:24]));
    h3 = int'(cal_press_hum[47:40]);
    h4 = int'($signed(cal_hum[11:0]));
    h5 = int'($signed(cal_hum[23:12]));
    h6 = int'($signed(cal_hum[31:24]));

    d1 = longint'(at >> 3) - 2 * t1;
    d2 = longint'(at >> 4) - t1;
    e1 = (d1 * t2) >>> 11;
    e2 = (((d2 * d2) >>> 12) * t3) >>> 14;
    t_fine = int'(e1 + e2);
    tcl = ((longint'(t_fine) * 5 + 128) >>> 8) + longint'(cal_offset);
    if (tcl > 64'sd2147483647) tcl = 64'sd2147483647;
    if (tcl < -64'sd2147483648) tcl = -64'sd2147483648;
    res.temp_centi = int'(tcl);

    // pressure, 32-bit wrapping datapath
    v1 = (t_fine >>> 1) - 64000;
    q = v1 >>> 2;
    qq = q * q;
    v2 = (qq >>> 11) * p6;
    v2 = v2 + (v1 * p5) * 2;
    v2 = (v2 >>> 2) + p4 * 65536;
    pa = (p3 * (qq >>> 13)) >>> 3;
    pb = (p2 * v1) >>> 1;
    v1 = (pa + pb) >>> 18;
    v1 = ((32768 + v1) * p1) >>> 15;
    p = 0;
    if (v1 != 0) begin
      dv = unsigned'(v1);
      p = (32'd1048576 - 32'(ap)) - unsigned'(v2 >>> 12);
      p = p * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / dv;
      else p = (p / dv) * 32'd2;
      u = p >> 3;
      sq = int'((u * u) >> 13);
      c1 = (p9 * sq) >>> 12;
      c2 = (int'(p >> 2) * p8) >>> 13;
      s = (c1 + c2 + p7) >>> 4;
      p = p + unsigned'(s);
    end
    res.press_pa = p;

    h = t_fine - 76800;
    x1 = (int'(ah) * 16384 - h4 * 1048576 - h5 * h + 16384) >>> 15;
    y1 = (h * h6) >>> 10;
    y2 = ((h * h3) >>> 11) + 32768;
    y = (y1 * y2) >>> 10;
    y = y + 2097152;
    y = (y * h2 + 8192) >>> 14;
    h = x1 * y;
    r = h >>> 15;
    z = (r * r) >>> 7;
    z = (z * h1) >>> 4;
    h = h - z;
    if (h < 0) h = 0;
    if (h > 419430400) h = 419430400;
    res.hum_q10 = h[28:12];
    return res;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TEMP_COEFS: cal_temp = val[47:0];
      REG_PRESS_LOW: cal_press_lo = val;
      REG_PRESS_HIGH: cal_press_hi = val;
      REG_PRESS_HUM: cal_press_hum = val[47:0];
      REG_HUM_COEFS: cal_hum = val[31:0];
      REG_TEMP_OFFSET: cal_offset = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_cal(input logic [47:0] tc, input logic [63:0] pl, input logic [63:0] ph,
                          input logic [47:0] phu, input logic [31:0] hu,
                          input logic [15:0] off);
    write_reg(REG_TEMP_COEFS, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | {16'h0, tc});
    write_reg(REG_PRESS_LOW, pl);
    write_reg(REG_PRESS_HIGH, ph);
    write_reg(REG_PRESS_HUM, {16'hA5A5, phu});
    write_reg(REG_HUM_COEFS, {32'h5A5A_5A5A, hu});
    write_reg(REG_TEMP_OFFSET, {48'h1234_5678_9ABC, off});
  endtask

  task automatic load_typical_cal();
    load_cal({16'hFC18, 16'd26435, 16'd27504},
             {16'd2855, 16'd3024, 16'hD643, 16'd36477},
             {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
             {8'd0, 16'd362, 8'd75, 16'd6000},
             {8'd30, 12'd50, 12'd313}, 16'd0);
  endtask

  // one word on the reading channel, with an optional idle burst ahead of it
  task automatic send_reading(input logic [19:0] ap, input logic [19:0] at,
                              input logic [15:0] ah);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.adc_pressure <= ap;
    in_ch.adc_temperature <= at;
    in_ch.adc_humidity <= ah;
    do @(posedge clk); while (!in_ch.ready);
    predicted_readings.push_back(compensate(ap, at, ah));
  endtask

  task automatic send_random(input int n);
    logic [19:0] ap, at;
    logic [15:0] ah;
    repeat (n) begin
      ap = 20'($urandom);
      at = 20'($urandom);
      ah = 16'($urandom);
      case ($urandom_range(0, 9))
        0: ap = $urandom_range(0, 1) ? 20'h0 : 20'hFFFFF;
        1: at = $urandom_range(0, 1) ? 20'h0 : 20'hFFFFF;
        2: ah = $urandom_range(0, 1) ? 16'h0 : 16'hFFFF;
        3, 4, 5: begin
          // plausible conversions around room conditions
          ap = 20'($urandom_range(250000, 600000));
          at = 20'($urandom_range(400000, 600000));
          ah = 16'($urandom_range(20000, 40000));
        end
        default: ;
      endcase
      send_reading(ap, at, ah);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (predicted_readings.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic test_zero_divisor();
    // all coefficients zero after reset: pressure divisor is zero
    send_reading(20'h0, 20'h0, 16'h0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_reading(20'h55555, 20'hAAAAA, 16'h5555);
    send_reading(20'hAAAAA, 20'h55555, 16'hAAAA);
    drain();
  endtask

  task automatic test_typical_cal();
    load_typical_cal();
    send_reading(20'd415148, 20'd519888, 16'd30000);
    send_reading(20'd0, 20'd519888, 16'd0);
    send_reading(20'hFFFFF, 20'd519888, 16'hFFFF);
    send_reading(20'd415148, 20'd0, 16'd30000);
    send_reading(20'd415148, 20'hFFFFF, 16'd30000);
    send_reading(20'h0, 20'h0, 16'hFFFF);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'h0);
    send_reading(20'd300000, 20'd450000, 16'd40000);
    drain();
    write_reg(REG_TEMP_OFFSET, 64'h7FFF);
    send_reading(20'd415148, 20'hFFFFF, 16'd30000);
    drain();
    write_reg(REG_TEMP_OFFSET, 64'h8000);
    send_reading(20'd415148, 20'h0, 16'd30000);
    drain();
  endtask

  task automatic test_spare_index();
    write_reg(REG_SPARE_A, {$urandom, $urandom});
    write_reg(REG_SPARE_B, {$urandom, $urandom});
    send_reading(20'd415148, 20'd519888, 16'd30000);
    send_random(20);
    drain();
  endtask

  task automatic test_extreme_cal();
    load_cal('1, '1, '1, '1, '1, 16'h7FFF);
    send_random(100);
    drain();
    load_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {4{16'h7FFF}}, {4{16'h8000}},
             {8'hFF, 16'h8000, 8'hFF, 16'h7FFF}, {8'h80, 12'h800, 12'h7FF}, 16'h8000);
    send_random(100);
    drain();
  endtask

  task automatic test_random_cal();
    repeat (4) begin
      load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
               48'({$urandom, $urandom}), $urandom, 16'($urandom));
      send_random(250);
      drain();
    end
  endtask

  task automatic test_back_to_back();
    load_typical_cal();
    idle_on = 1'b0;
    send_random(400);
    drain();
  endtask

  // sink side: ready in random runs and stall bursts
  initial begin
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (predicted_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycle_count);
      end else begin
        want = predicted_readings.pop_front();
        if (out_ch.temperature_centi !== want.temp_centi || out_ch.pressure_pa !== want.press_pa
            || out_ch.humidity_q10 !== want.hum_q10) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: temp %0d/%0d press %0d/%0d hum %0d/%0d (exp/act)",
                     want.temp_centi, out_ch.temperature_centi, want.press_pa,
                     out_ch.pressure_pa, want.hum_q10, out_ch.humidity_q10);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_sensor_reading_compensation_top: errors");
      $finish;
    end
  end

  initial begin
    cal_temp = '0;
    cal_press_lo = '0;
    cal_press_hi = '0;
    cal_press_hum = '0;
    cal_hum = '0;
    cal_offset = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_divisor();
    test_typical_cal();
    test_spare_index();
    test_extreme_cal();
    test_random_cal();
    test_back_to_back();
    if (mismatches == 0 && predicted_readings.size() == 0)
      $display("tb_sensor_reading_compensation_top: clean");
    else
      $display("tb_sensor_reading_compensation_top: errors");
    $finish;
  end

endmodule
